[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: condition does not hold");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

[sv/mid_pkg.sv]
// shared types and constants of the message-id validator
`default_nettype none
package mid_pkg;

  // widths and limits
  localparam int LEN_W       = 10;
  localparam int LEN_CAP     = 1023;
  localparam int MAX_LEN_DEF = 1023;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // byte codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_RBRACK   = 8'h5D;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_PRINT_LO = 8'd33;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  // class of one input byte
  typedef enum logic [3:0] {
    CL_NUL,
    CL_LT,
    CL_GT,
    CL_AT,
    CL_QUOTE,
    CL_LBRACK,
    CL_RBRACK,
    CL_BSLASH,
    CL_PRINT,
    CL_OTHER
  } byte_class_t;

  // one word in the queue between front and back
  typedef struct packed {
    byte_class_t cls;
    logic        last;
  } mid_entry_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_OPEN,
    PH_LEFT_START,
    PH_LEFT,
    PH_AT,
    PH_RIGHT_START,
    PH_RIGHT,
    PH_CLOSE,
    PH_SWALLOW
  } phase_t;

  // verdict of one step
  typedef enum logic [1:0] {
    V_NONE,
    V_BAD,
    V_GOOD
  } verdict_t;

endpackage
`default_nettype wire

[sv/mid_front.sv]
// front end: takes input words and classifies each byte
`default_nettype none
module mid_front (
  input  wire logic                push,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last,
  input  wire logic                q_full,
  output logic                     full,
  output logic                     q_wr,
  output mid_pkg::mid_entry_t      q_entry
);

  // byte classifier
  function automatic mid_pkg::byte_class_t classify(input logic [7:0] b);
    mid_pkg::byte_class_t c;
    if (b == mid_pkg::CH_NUL) c = mid_pkg::CL_NUL;
    else if (b == mid_pkg::CH_LT) c = mid_pkg::CL_LT;
    else if (b == mid_pkg::CH_GT) c = mid_pkg::CL_GT;
    else if (b == mid_pkg::CH_AT) c = mid_pkg::CL_AT;
    else if (b == mid_pkg::CH_QUOTE) c = mid_pkg::CL_QUOTE;
    else if (b == mid_pkg::CH_LBRACK) c = mid_pkg::CL_LBRACK;
    else if (b == mid_pkg::CH_RBRACK) c = mid_pkg::CL_RBRACK;
    else if (b == mid_pkg::CH_BSLASH) c = mid_pkg::CL_BSLASH;
    else if (b inside {[mid_pkg::CH_PRINT_LO:mid_pkg::CH_PRINT_HI]}) c = mid_pkg::CL_PRINT;
    else c = mid_pkg::CL_OTHER;
    return c;
  endfunction

  // accept a word whenever the queue has room
  assign full         = q_full;
  assign q_wr         = push && !q_full;
  assign q_entry.cls  = classify(data_byte);
  assign q_entry.last = last;

endmodule
`default_nettype wire

[sv/mid_fifo.sv]
// short queue of classified bytes between front and back
`default_nettype none
module mid_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr,
  input  wire mid_pkg::mid_entry_t wr_entry,
  input  wire logic                rd,
  output logic                     full,
  output logic                     rd_valid,
  output mid_pkg::mid_entry_t      rd_entry
);

  mid_pkg::mid_entry_t             mem [mid_pkg::QUEUE_DEPTH];
  logic [mid_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [mid_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [mid_pkg::Q_CNT_W-1:0]     count;

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  // status and head word
  assign full     = (count == mid_pkg::Q_CNT_W'(mid_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];

endmodule
`default_nettype wire

[sv/mid_back.sv]
// back end: syntax state machine and result register
`default_nettype none
module mid_back #(
  parameter int MAX_LEN = mid_pkg::MAX_LEN_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_valid,
  input  wire mid_pkg::mid_entry_t       q_entry,
  output logic                           q_rd,
  input  wire logic                      pop,
  output logic                           empty,
  output logic                           valid_res,
  output logic [mid_pkg::LEN_W-1:0]      id_length
);

  localparam logic [mid_pkg::LEN_W-1:0] LIMIT = (MAX_LEN > mid_pkg::LEN_CAP) ?
    mid_pkg::LEN_W'(mid_pkg::LEN_CAP) : mid_pkg::LEN_W'(MAX_LEN);

  mid_pkg::phase_t             phase, phase_next;
  logic                        in_quotes, in_quotes_next;
  logic                        in_brackets, in_brackets_next;
  logic                        escape_pending, escape_pending_next;
  logic                        part_nonempty, part_nonempty_next;
  logic [mid_pkg::LEN_W-1:0]   byte_count, byte_count_next;
  mid_pkg::verdict_t           verdict;
  logic                        do_left, do_right;

  logic                        res_valid;
  logic                        res_good;
  logic [mid_pkg::LEN_W-1:0]   res_len;
  logic                        res_good_next;
  logic [mid_pkg::LEN_W-1:0]   res_len_next;
  logic                        res_load;

  mid_pkg::byte_class_t        cls;
  assign cls = q_entry.cls;

  // next state of the parser for the head word
  always_comb begin
    phase_next          = phase;
    in_quotes_next      = in_quotes;
    in_brackets_next    = in_brackets;
    escape_pending_next = escape_pending;
    part_nonempty_next  = part_nonempty;
    byte_count_next     = byte_count;
    verdict             = mid_pkg::V_NONE;
    do_left             = 1'b0;
    do_right            = 1'b0;

    if (phase != mid_pkg::PH_SWALLOW) begin
      if (byte_count >= LIMIT || cls == mid_pkg::CL_NUL) begin
        verdict = mid_pkg::V_BAD;
      end else begin
        byte_count_next = byte_count + 1'b1;
        case (phase)
          mid_pkg::PH_OPEN: begin
            if (cls == mid_pkg::CL_LT) phase_next = mid_pkg::PH_LEFT_START;
            else verdict = mid_pkg::V_BAD;
          end
          mid_pkg::PH_LEFT_START: begin
            phase_next = mid_pkg::PH_LEFT;
            if (cls == mid_pkg::CL_QUOTE) begin
              in_quotes_next     = 1'b1;
              part_nonempty_next = 1'b1;
            end else begin
              do_left = 1'b1;
            end
          end
          mid_pkg::PH_LEFT: begin
            do_left = 1'b1;
          end
          mid_pkg::PH_AT: begin
            if (cls == mid_pkg::CL_AT) begin
              phase_next         = mid_pkg::PH_RIGHT_START;
              part_nonempty_next = 1'b0;
            end else begin
              verdict = mid_pkg::V_BAD;
            end
          end
          mid_pkg::PH_RIGHT_START: begin
            phase_next = mid_pkg::PH_RIGHT;
            if (cls == mid_pkg::CL_LBRACK) begin
              in_brackets_next   = 1'b1;
              part_nonempty_next = 1'b1;
            end else begin
              do_right = 1'b1;
            end
          end
          mid_pkg::PH_RIGHT: begin
            do_right = 1'b1;
          end
          default: begin
            verdict = (cls == mid_pkg::CL_GT) ? mid_pkg::V_GOOD : mid_pkg::V_BAD;
          end
        endcase

        // body of the left part
        if (do_left) begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            part_nonempty_next  = 1'b1;
          end else begin
            case (cls)
              mid_pkg::CL_QUOTE: begin
                if (!in_quotes) verdict = mid_pkg::V_BAD;
                else phase_next = mid_pkg::PH_AT;
              end
              mid_pkg::CL_BSLASH: begin
                escape_pending_next = 1'b1;
                part_nonempty_next  = 1'b1;
              end
              mid_pkg::CL_AT: begin
                if (in_quotes || !part_nonempty) begin
                  verdict = mid_pkg::V_BAD;
                end else begin
                  phase_next         = mid_pkg::PH_RIGHT_START;
                  part_nonempty_next = 1'b0;
                end
              end
              mid_pkg::CL_PRINT, mid_pkg::CL_LT,
              mid_pkg::CL_LBRACK, mid_pkg::CL_RBRACK: begin
                part_nonempty_next = 1'b1;
              end
              default: verdict = mid_pkg::V_BAD;
            endcase
          end
        end

        // body of the right part
        if (do_right) begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            part_nonempty_next  = 1'b1;
          end else begin
            case (cls)
              mid_pkg::CL_RBRACK: begin
                if (!in_brackets) verdict = mid_pkg::V_BAD;
                else phase_next = mid_pkg::PH_CLOSE;
              end
              mid_pkg::CL_BSLASH: begin
                escape_pending_next = 1'b1;
                part_nonempty_next  = 1'b1;
              end
              mid_pkg::CL_GT: begin
                if (in_brackets || !part_nonempty) verdict = mid_pkg::V_BAD;
                else verdict = mid_pkg::V_GOOD;
              end
              mid_pkg::CL_PRINT, mid_pkg::CL_LT,
              mid_pkg::CL_QUOTE, mid_pkg::CL_AT: begin
                part_nonempty_next = 1'b1;
              end
              default: verdict = mid_pkg::V_BAD;
            endcase
          end
        end
      end

      if (verdict == mid_pkg::V_NONE && q_entry.last) verdict = mid_pkg::V_BAD;
      if (verdict != mid_pkg::V_NONE) phase_next = mid_pkg::PH_SWALLOW;
    end

    // end of string returns to the idle state
    if (q_entry.last) begin
      phase_next          = mid_pkg::PH_OPEN;
      in_quotes_next      = 1'b0;
      in_brackets_next    = 1'b0;
      escape_pending_next = 1'b0;
      part_nonempty_next  = 1'b0;
      byte_count_next     = '0;
    end
  end

  // handshake and result word, length includes the closing byte
  always_comb begin
    q_rd          = q_valid && (!res_valid || pop);
    res_load      = q_rd && (verdict != mid_pkg::V_NONE);
    res_good_next = (verdict == mid_pkg::V_GOOD);
    res_len_next  = (verdict == mid_pkg::V_GOOD) ? byte_count + 1'b1 : '0;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mid_pkg::PH_OPEN;
      in_quotes      <= 1'b0;
      in_brackets    <= 1'b0;
      escape_pending <= 1'b0;
      part_nonempty  <= 1'b0;
      byte_count     <= '0;
    end else if (q_rd) begin
      phase          <= phase_next;
      in_quotes      <= in_quotes_next;
      in_brackets    <= in_brackets_next;
      escape_pending <= escape_pending_next;
      part_nonempty  <= part_nonempty_next;
      byte_count     <= byte_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_good <= res_good_next;
      res_len  <= res_len_next;
    end
  end

  assign empty     = !res_valid;
  assign valid_res = res_good;
  assign id_length = res_len;

endmodule
`default_nettype wire

[sv/message_id_validator_unit.sv]
// Message-ID syntax checker, one byte word per cycle in, one verdict word out.
// Throughput: one byte per cycle, sustained while results are popped.
// A verdict passes through the queue and then the result register before it is
// visible; a four-word queue decouples the input from the parser.
// Reset: synchronous; empties the queue and result register, parser to idle.
`default_nettype none
`include "assert_macros.svh"
module message_id_validator_unit #(
  parameter int MAX_LEN = mid_pkg::MAX_LEN_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      last,
  output logic                           empty,
  input  wire logic                      pop,
  output logic                           valid_res,
  output logic [mid_pkg::LEN_W-1:0]      id_length
);

  logic                 q_full;
  logic                 q_wr;
  mid_pkg::mid_entry_t  q_wr_entry;
  logic                 q_rd;
  logic                 q_valid;
  mid_pkg::mid_entry_t  q_rd_entry;

  // classifier
  mid_front u_front (
    .push      (push),
    .data_byte (data_byte),
    .last      (last),
    .q_full    (q_full),
    .full      (full),
    .q_wr      (q_wr),
    .q_entry   (q_wr_entry)
  );

  // decoupling queue
  mid_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (q_wr_entry),
    .rd       (q_rd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_entry (q_rd_entry)
  );

  // parser and result register
  mid_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_rd_entry),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .valid_res (valid_res),
    .id_length (id_length)
  );

  // checks
  `ASSERT_IMPLIES(a_no_write_when_full, clk, rst, q_full, !q_wr)
  `ASSERT_IMPLIES(a_read_needs_data, clk, rst, q_rd, q_valid)
  `ASSERT_IMPLIES(a_bad_has_no_length, clk, rst, !empty && !valid_res, id_length == '0)
  `ASSERT_IMPLIES(a_good_min_length, clk, rst, !empty && valid_res,
                  id_length >= mid_pkg::LEN_W'(5))

endmodule
`default_nettype wire
